// ===== src/lobm_pkg.sv =====
// shared codes and constants for the order book matcher
`default_nettype none
package lobm_pkg;
    localparam logic [1:0] FUNC_LIMIT  = 2'd0;
    localparam logic [1:0] FUNC_MARKET = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [2:0] ST_REJECTED = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_PARTIAL  = 3'd2;
    localparam logic [2:0] ST_FILLED   = 3'd3;
    localparam logic [2:0] ST_CANCELLED = 3'd4;

    localparam logic [2:0] RC_NONE      = 3'd0;
    localparam logic [2:0] RC_ZERO_QTY  = 3'd1;
    localparam logic [2:0] RC_DUP_ID    = 3'd2;
    localparam logic [2:0] RC_NOT_FOUND = 3'd3;
    localparam logic [2:0] RC_BOOK_FULL = 3'd4;

    localparam logic [31:0] QTY_SAT = 32'hFFFF_FFFF;
endpackage
`default_nettype wire

// ===== src/limit_order_book_matcher.sv =====
// price-time priority order book with a bounded slot table and a serial scanner
//
//   channel | valid     | stall     | payload
//   in      | in_valid  | in_stall  | func ord_id side price qty
//   out     | out_valid | out_stall | status .. last, one or more items per event
//
// one slot is examined per cycle by a shared compare unit; each scan visits
// every slot in turn. a limit order costs a lookup scan, one best-price scan
// per trade plus one more unless it fills or reaches MAX_ORDERS trades, a
// free-slot scan unless it fills and two top-of-book passes of two scans each.
// a market order skips the lookup and free-slot scans; a cancel takes the
// lookup scan, the cancel state, the top-of-book passes and the summary.
// in_stall is high from the cycle after acceptance until the summary item is
// taken. out_stall holds each result in its output register. reset clears the
// valid bits and the arrival counter.
`default_nettype none
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int MAX_ORDERS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [1:0]  func,
    input  wire  [31:0] ord_id,
    input  wire         side,
    input  wire  [31:0] price,
    input  wire  [31:0] qty,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [2:0]  status,
    output logic [2:0]  reject_cause,
    output logic [31:0] resting_id,
    output logic [31:0] trade_price,
    output logic [31:0] fill_qty,
    output logic [31:0] filled_total,
    output logic [31:0] left_qty,
    output logic [31:0] bid_px,
    output logic [31:0] bid_size,
    output logic [31:0] ask_px,
    output logic [31:0] ask_size,
    output logic        last
);
    localparam int IW = $clog2(MAX_ORDERS);
    localparam int CW = $clog2(MAX_ORDERS + 1);
    localparam logic [CW-1:0] NSLOT = CW'(MAX_ORDERS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND  = 4'd1;  // id lookup
    localparam logic [3:0] S_BEST  = 4'd2;  // best opposite slot
    localparam logic [3:0] S_TRADE = 4'd3;  // apply a trade, emit execution
    localparam logic [3:0] S_FREE  = 4'd4;  // lowest free slot
    localparam logic [3:0] S_TOPB  = 4'd5;  // best price on a side
    localparam logic [3:0] S_TOPQ  = 4'd6;  // sum qty at that price
    localparam logic [3:0] S_SUM   = 4'd7;  // emit summary
    localparam logic [3:0] S_WAIT  = 4'd8;  // output handshake
    localparam logic [3:0] S_CANC  = 4'd9;  // apply cancel

    logic              vld_reg [MAX_ORDERS];
    logic [31:0]       id_mem    [MAX_ORDERS];
    logic              side_mem  [MAX_ORDERS];
    logic [31:0]       price_mem [MAX_ORDERS];
    logic [31:0]       qty_mem   [MAX_ORDERS];
    logic [31:0]       arr_mem   [MAX_ORDERS];

    logic [3:0]   state_reg, ret_reg;
    logic [CW-1:0] idx_reg;
    logic [1:0]   func_reg;
    logic [31:0]  oid_reg, lprice_reg, qty_reg, rem_reg;
    logic         side_reg;
    logic [31:0]  arrival_reg;
    logic         hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [31:0]  hit_price_reg, hit_age_reg;
    logic [5:0]   ntrade_reg;
    logic         tside_reg;
    logic [32:0]  sum_reg;
    logic [2:0]   st_reg, rc_reg;
    logic [31:0]  bb_reg, bbq_reg;
    logic         done_reg;

    logic [IW-1:0] idx;
    logic          v;
    logic [31:0]   age;
    logic          better;
    assign idx = idx_reg[IW-1:0];
    assign v   = vld_reg[idx];
    assign age = arrival_reg - arr_mem[idx];

    always_comb
    begin
        better = 1'b0;
        if (!hit_reg)
            better = 1'b1;
        else if (price_mem[idx] != hit_price_reg)
            better = tside_reg ? (price_mem[idx] < hit_price_reg)
                               : (price_mem[idx] > hit_price_reg);
        else
            better = age > hit_age_reg;
    end

    assign in_stall = (state_reg != S_IDLE);

    function automatic logic [31:0] fill_amount();
        return (rem_reg < qty_mem[hit_idx_reg]) ? rem_reg : qty_mem[hit_idx_reg];
    endfunction

    function automatic logic [31:0] cancel_left();
        logic [31:0] q;
        q = qty_mem[hit_idx_reg];
        return (qty_reg == 32'd0 || qty_reg >= q) ? 32'd0 : q - qty_reg;
    endfunction

    always_ff @(posedge clk)
    begin
        if (state_reg == S_TRADE)
        begin
            qty_mem[hit_idx_reg] <= qty_mem[hit_idx_reg] - fill_amount();
        end
        else if (state_reg == S_CANC && hit_reg)
        begin
            qty_mem[hit_idx_reg] <= cancel_left();
        end
        else if (state_reg == S_FREE && idx_reg == NSLOT && hit_reg)
        begin
            id_mem[hit_idx_reg]    <= oid_reg;
            side_mem[hit_idx_reg]  <= side_reg;
            price_mem[hit_idx_reg] <= lprice_reg;
            qty_mem[hit_idx_reg]   <= rem_reg;
            arr_mem[hit_idx_reg]   <= arrival_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            out_valid   <= 1'b0;
            arrival_reg <= 32'd0;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
            for (int i = 0; i < MAX_ORDERS; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg   <= func;
                        oid_reg    <= ord_id;
                        side_reg   <= side;
                        lprice_reg <= price;
                        qty_reg    <= (func == FUNC_UNUSED) ? 32'd0 : qty;
                        rem_reg    <= (func == FUNC_UNUSED) ? 32'd0 : qty;
                        ntrade_reg <= '0;
                        idx_reg    <= '0;
                        hit_reg    <= 1'b0;
                        rc_reg     <= (func != FUNC_UNUSED && func != FUNC_CANCEL &&
                                       qty == 32'd0) ? RC_ZERO_QTY : RC_NONE;
                        if (func == FUNC_UNUSED)
                        begin
                            st_reg <= ST_REJECTED;
                            tside_reg <= 1'b0;
                            state_reg <= S_TOPB;
                        end
                        else if (func != FUNC_CANCEL && qty == 32'd0)
                        begin
                            st_reg <= ST_REJECTED;
                            tside_reg <= 1'b0;
                            state_reg <= S_TOPB;
                        end
                        else if (func == FUNC_MARKET)
                        begin
                            tside_reg <= ~side;
                            state_reg <= S_BEST;
                        end
                        else
                            state_reg <= S_FIND;
                    end
                end
                S_FIND:
                begin
                    if (idx_reg == NSLOT)
                    begin
                        idx_reg <= '0;
                        if (func_reg == FUNC_CANCEL)
                            state_reg <= S_CANC;
                        else if (hit_reg)
                        begin
                            st_reg <= ST_REJECTED;
                            rc_reg <= RC_DUP_ID;
                            rem_reg <= 32'd0;
                            qty_reg <= 32'd0;
                            hit_reg <= 1'b0;
                            tside_reg <= 1'b0;
                            state_reg <= S_TOPB;
                        end
                        else
                        begin
                            tside_reg <= ~side_reg;
                            state_reg <= S_BEST;
                        end
                    end
                    else
                    begin
                        if (!hit_reg && v && id_mem[idx] == oid_reg)
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= idx;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_CANC:
                begin
                    if (!hit_reg)
                    begin
                        st_reg <= ST_REJECTED;
                        rc_reg <= RC_NOT_FOUND;
                    end
                    else
                    begin
                        st_reg <= ST_CANCELLED;
                        if (cancel_left() == 32'd0)
                            vld_reg[hit_idx_reg] <= 1'b0;
                    end
                    // filled comes out as zero since qty and rem agree
                    rem_reg   <= hit_reg ? cancel_left() : 32'd0;
                    qty_reg   <= hit_reg ? cancel_left() : 32'd0;
                    hit_reg   <= 1'b0;
                    tside_reg <= 1'b0;
                    idx_reg   <= '0;
                    state_reg <= S_TOPB;
                end
                S_BEST:
                begin
                    if (idx_reg == NSLOT)
                    begin
                        idx_reg <= '0;
                        if (hit_reg && (func_reg == FUNC_MARKET ||
                            (side_reg == 1'b0 && lprice_reg >= hit_price_reg) ||
                            (side_reg == 1'b1 && lprice_reg <= hit_price_reg)))
                            state_reg <= S_TRADE;
                        else
                        begin
                            hit_reg   <= 1'b0;
                            state_reg <= (func_reg == FUNC_LIMIT) ? S_FREE : S_TOPB;
                            if (func_reg != FUNC_LIMIT)
                            begin
                                st_reg <= (rem_reg != qty_reg) ? ST_PARTIAL : ST_ACCEPTED;
                                tside_reg <= 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        if (v && side_mem[idx] == tside_reg && better)
                        begin
                            hit_reg       <= 1'b1;
                            hit_idx_reg   <= idx;
                            hit_price_reg <= price_mem[idx];
                            hit_age_reg   <= age;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_TRADE:
                begin
                    out_valid    <= 1'b1;
                    status       <= ST_REJECTED;
                    reject_cause <= RC_NONE;
                    resting_id   <= id_mem[hit_idx_reg];
                    trade_price  <= price_mem[hit_idx_reg];
                    fill_qty     <= fill_amount();
                    filled_total <= 32'd0;
                    left_qty     <= 32'd0;
                    bid_px       <= 32'd0;
                    bid_size     <= 32'd0;
                    ask_px       <= 32'd0;
                    ask_size     <= 32'd0;
                    last         <= 1'b0;
                    if (qty_mem[hit_idx_reg] == fill_amount())
                        vld_reg[hit_idx_reg] <= 1'b0;
                    rem_reg    <= rem_reg - fill_amount();
                    ntrade_reg <= ntrade_reg + 1'b1;
                    hit_reg    <= 1'b0;
                    idx_reg    <= '0;
                    if (rem_reg == fill_amount() || ntrade_reg == 6'(MAX_ORDERS - 1))
                        ret_reg <= (func_reg == FUNC_LIMIT && rem_reg != fill_amount())
                                   ? S_FREE : S_SUM;
                    else
                        ret_reg <= S_BEST;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        if (done_reg)
                        begin
                            done_reg  <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else if (ret_reg == S_SUM)
                        begin
                            // all remaining done: status from rem
                            st_reg <= (rem_reg == 32'd0) ? ST_FILLED : ST_PARTIAL;
                            tside_reg <= 1'b0;
                            state_reg <= S_TOPB;
                        end
                        else
                            state_reg <= ret_reg;
                    end
                end
                S_FREE:
                begin
                    if (idx_reg == NSLOT)
                    begin
                        if (hit_reg)
                        begin
                            vld_reg[hit_idx_reg] <= 1'b1;
                            arrival_reg <= arrival_reg + 1'b1;
                            st_reg <= (rem_reg == qty_reg) ? ST_ACCEPTED : ST_PARTIAL;
                        end
                        else
                        begin
                            rc_reg <= RC_BOOK_FULL;
                            st_reg <= (rem_reg == qty_reg) ? ST_REJECTED : ST_PARTIAL;
                        end
                        hit_reg   <= 1'b0;
                        idx_reg   <= '0;
                        tside_reg <= 1'b0;
                        state_reg <= S_TOPB;
                    end
                    else
                    begin
                        if (!hit_reg && !v)
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= idx;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_TOPB:
                begin
                    if (idx_reg == NSLOT)
                    begin
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_TOPQ;
                    end
                    else
                    begin
                        if (v && side_mem[idx] == tside_reg && better)
                        begin
                            hit_reg       <= 1'b1;
                            hit_price_reg <= price_mem[idx];
                            hit_age_reg   <= age;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_TOPQ:
                begin
                    if (idx_reg == NSLOT)
                    begin
                        idx_reg <= '0;
                        if (!tside_reg)
                        begin
                            hit_reg   <= 1'b0;
                            bb_reg    <= hit_reg ? hit_price_reg : 32'd0;
                            bbq_reg   <= sum_reg[32] ? QTY_SAT : sum_reg[31:0];
                            tside_reg <= 1'b1;
                            state_reg <= S_TOPB;
                        end
                        else
                            // ask side stays in the hit registers for the summary
                            state_reg <= S_SUM;
                    end
                    else
                    begin
                        if (hit_reg && v && side_mem[idx] == tside_reg &&
                            price_mem[idx] == hit_price_reg && !sum_reg[32])
                            sum_reg <= sum_reg + {1'b0, qty_mem[idx]};
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SUM:
                begin
                    out_valid    <= 1'b1;
                    status       <= st_reg;
                    reject_cause <= rc_reg;
                    resting_id   <= 32'd0;
                    trade_price  <= 32'd0;
                    fill_qty     <= 32'd0;
                    filled_total <= qty_reg - rem_reg;
                    left_qty     <= rem_reg;
                    bid_px       <= bb_reg;
                    bid_size     <= bbq_reg;
                    ask_px       <= hit_reg ? hit_price_reg : 32'd0;
                    ask_size     <= hit_reg ? (sum_reg[32] ? QTY_SAT : sum_reg[31:0])
                                            : 32'd0;
                    last         <= 1'b1;
                    done_reg     <= 1'b1;
                    state_reg    <= S_WAIT;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/lobm_checker.sv =====
// port-level checks for the order book matcher, bound to the top level
`default_nettype none
module lobm_checker
    import lobm_pkg::*;
(
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire        out_valid,
    input wire        out_stall,
    input wire        last,
    input wire [2:0]  status,
    input wire [2:0]  reject_cause
);
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("not busy after accept");
    a_no_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("result while idle");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(last) && $stable(status))
        else $error("result changed under stall");
    a_exec_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> status == ST_REJECTED && reject_cause == RC_NONE)
        else $error("execution item carries status");
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .last(last),
    .status(status), .reject_cause(reject_cause)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the limit order book matcher
`default_nettype none
module tb_top
    import lobm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SLOTS       = 32;
    localparam int          QUIET_TAIL  = 30;
    localparam int          DOG_LIMIT   = 40000;
    localparam int          SETTLE      = 400;
    localparam int          DIRECTED_N  = 20;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] id;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
        bit          drain;
        bit          has_exp;
        logic [2:0]  exp_status;
        logic [2:0]  exp_cause;
    } order_t;

    typedef struct {
        logic [2:0]  status;
        logic [2:0]  cause;
        logic [31:0] rid;
        logic [31:0] tprice;
        logic [31:0] tqty;
        logic [31:0] filled;
        logic [31:0] left;
        logic [31:0] bid;
        logic [31:0] bid_qty;
        logic [31:0] ask;
        logic [31:0] ask_qty;
        logic        last;
    } report_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [31:0] ord_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [2:0]  reject_cause;
    logic [31:0] resting_id;
    logic [31:0] trade_price;
    logic [31:0] fill_qty;
    logic [31:0] filled_total;
    logic [31:0] left_qty;
    logic [31:0] bid_px;
    logic [31:0] bid_size;
    logic [31:0] ask_px;
    logic [31:0] ask_size;
    logic        last;

    limit_order_book_matcher #(.MAX_ORDERS(SLOTS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .ord_id(ord_id), .side(side), .price(price), .qty(qty),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .reject_cause(reject_cause), .resting_id(resting_id),
        .trade_price(trade_price), .fill_qty(fill_qty),
        .filled_total(filled_total), .left_qty(left_qty),
        .bid_px(bid_px), .bid_size(bid_size),
        .ask_px(ask_px), .ask_size(ask_size), .last(last)
    );

    // book mirror
    bit          book_live [SLOTS];
    logic [31:0] book_id [SLOTS];
    logic        book_side [SLOTS];
    logic [31:0] book_price [SLOTS];
    logic [31:0] book_qty [SLOTS];
    logic [31:0] book_arrival [SLOTS];
    logic [31:0] arrivals;

    order_t  directed [DIRECTED_N];
    order_t  orders[$];
    report_t due_reports[$];
    int      errors;
    int      next_order;
    int      in_gap;
    int      out_hold;
    int      idle_cycles;
    bit      quiet;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on %s: got %0h, want %0h", what, got, want);
        errors++;
    endtask

    function automatic int find_order(input logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (book_live[i] && book_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int best_resting(input logic s);
        int b;
        b = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!book_live[i] || book_side[i] != s)
                continue;
            if (b < 0)
                b = i;
            else if (book_price[i] != book_price[b]) begin
                if (s == 1'b0 ? book_price[i] > book_price[b] : book_price[i] < book_price[b])
                    b = i;
            end
            else if (32'(arrivals - book_arrival[i]) > 32'(arrivals - book_arrival[b]))
                b = i;
        end
        return b;
    endfunction

    task automatic level_of(input logic s, output logic [31:0] p, output logic [31:0] q);
        int          b;
        logic [63:0] sum;
        b = best_resting(s);
        sum = '0;
        p = '0;
        q = '0;
        if (b >= 0) begin
            for (int i = 0; i < SLOTS; i++)
                if (book_live[i] && book_side[i] == s && book_price[i] == book_price[b])
                    sum += book_qty[i];
            p = book_price[b];
            q = (sum > 64'(QTY_SAT)) ? QTY_SAT : sum[31:0];
        end
    endtask

    task automatic push_summary(input logic [2:0] st, input logic [2:0] rc,
                                input logic [31:0] filled, input logic [31:0] left);
        report_t r;
        r = '{default: '0};
        r.status = st;
        r.cause = rc;
        r.filled = filled;
        r.left = left;
        level_of(1'b0, r.bid, r.bid_qty);
        level_of(1'b1, r.ask, r.ask_qty);
        r.last = 1'b1;
        due_reports = {due_reports, r};
    endtask

    // advances the book mirror by one event and queues what it should emit
    task automatic match_event(input order_t e);
        int          k;
        int          b;
        int          trades;
        int          f;
        logic [31:0] rem;
        logic [31:0] t;
        logic [31:0] cut;
        logic [2:0]  rc;
        logic [2:0]  st;
        report_t     r;
        trades = 0;
        rc = RC_NONE;
        if (e.func == FUNC_UNUSED) begin
            push_summary(ST_REJECTED, RC_NONE, 0, 0);
            return;
        end
        if (e.func == FUNC_CANCEL) begin
            k = find_order(e.id);
            if (k < 0) begin
                push_summary(ST_REJECTED, RC_NOT_FOUND, 0, 0);
                return;
            end
            cut = (e.qty == 0 || e.qty >= book_qty[k]) ? book_qty[k] : e.qty;
            book_qty[k] -= cut;
            if (book_qty[k] == 0)
                book_live[k] = 1'b0;
            push_summary(ST_CANCELLED, RC_NONE, 0, book_qty[k]);
            return;
        end
        if (e.qty == 0) begin
            push_summary(ST_REJECTED, RC_ZERO_QTY, 0, 0);
            return;
        end
        if (e.func == FUNC_LIMIT && find_order(e.id) >= 0) begin
            push_summary(ST_REJECTED, RC_DUP_ID, 0, 0);
            return;
        end
        rem = e.qty;
        while (rem > 0 && trades < SLOTS) begin
            b = best_resting(~e.side);
            if (b < 0)
                break;
            if (e.func == FUNC_LIMIT &&
                (e.side == 1'b0 ? e.price < book_price[b] : e.price > book_price[b]))
                break;
            t = (rem < book_qty[b]) ? rem : book_qty[b];
            r = '{default: '0};
            r.rid = book_id[b];
            r.tprice = book_price[b];
            r.tqty = t;
            due_reports = {due_reports, r};
            trades++;
            rem -= t;
            book_qty[b] -= t;
            if (book_qty[b] == 0)
                book_live[b] = 1'b0;
        end
        if (e.func == FUNC_LIMIT && rem > 0) begin
            f = -1;
            for (int i = 0; i < SLOTS; i++)
                if (!book_live[i]) begin
                    f = i;
                    break;
                end
            if (f < 0)
                rc = RC_BOOK_FULL;
            else begin
                book_live[f] = 1'b1;
                book_id[f] = e.id;
                book_side[f] = e.side;
                book_price[f] = e.price;
                book_qty[f] = rem;
                book_arrival[f] = arrivals;
                arrivals++;
            end
        end
        if (rc == RC_BOOK_FULL)
            st = (rem != e.qty) ? ST_PARTIAL : ST_REJECTED;
        else if (rem == 0)
            st = ST_FILLED;
        else if (rem != e.qty)
            st = ST_PARTIAL;
        else
            st = ST_ACCEPTED;
        push_summary(st, rc, e.qty - rem, rem);
    endtask

    task automatic add_order(input logic [1:0] f, input logic [31:0] id, input logic s,
                             input logic [31:0] p, input logic [31:0] q,
                             input bit chk = 0, input logic [2:0] st = ST_REJECTED,
                             input logic [2:0] rc = RC_NONE);
        order_t o;
        o.func = f;
        o.id = id;
        o.side = s;
        o.price = p;
        o.qty = q;
        o.drain = 1'b0;
        o.has_exp = chk;
        o.exp_status = st;
        o.exp_cause = rc;
        orders = {orders, o};
    endtask

    task automatic add_random_order();
        int          r;
        logic        s;
        logic [31:0] id;
        logic [31:0] p;
        logic [31:0] q;
        r = $urandom_range(0, 99);
        s = 1'($urandom_range(0, 1));
        id = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(1, 60));
        p = s ? 32'($urandom_range(100, 115)) : 32'($urandom_range(90, 105));
        if ($urandom_range(0, 19) == 0)
            p = $urandom;
        q = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(1, 25));
        if (r < 50)
            add_order(FUNC_LIMIT, id, s, p, q);
        else if (r < 65)
            add_order(FUNC_MARKET, id, s, $urandom, q);
        else if (r < 88)
            add_order(FUNC_CANCEL, id, s, $urandom,
                      $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(1, 15)));
        else if (r < 93)
            add_order(FUNC_UNUSED, $urandom, s, $urandom, $urandom);
        else
            add_order(($urandom_range(0, 1) != 0) ? FUNC_MARKET : FUNC_LIMIT,
                      id, s, p, 32'd0);
    endtask

    initial begin
        errors = 0;
        arrivals = '0;
        for (int i = 0; i < SLOTS; i++)
            book_live[i] = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        func = FUNC_LIMIT;
        ord_id = '0;
        side = 1'b0;
        price = '0;
        qty = '0;
        next_order = 0;
        in_gap = 0;
        out_hold = 0;
        idle_cycles = 0;
        quiet = 1'b0;

        // directed: empty book cases, extremes, matching, cancels
        // func, id, side, price, qty, drain, checked, status, cause
        directed = '{
            '{FUNC_CANCEL, 32'd5, 1'b0, 32'd0, 32'd0, 1'b0, 1'b1, ST_REJECTED, RC_NOT_FOUND},
            '{FUNC_LIMIT, 32'd7, 1'b0, 32'd10, 32'd0, 1'b0, 1'b1, ST_REJECTED, RC_ZERO_QTY},
            '{FUNC_MARKET, 32'd7, 1'b1, 32'd10, 32'd0, 1'b0, 1'b1, ST_REJECTED, RC_ZERO_QTY},
            '{FUNC_MARKET, 32'd8, 1'b0, 32'd0, 32'd10, 1'b0, 1'b1, ST_ACCEPTED, RC_NONE},
            '{FUNC_UNUSED, QTY_SAT, 1'b1, QTY_SAT, QTY_SAT, 1'b0, 1'b1, ST_REJECTED, RC_NONE},
            '{FUNC_LIMIT, 32'd1, 1'b1, 32'd100, 32'd50, 1'b0, 1'b1, ST_ACCEPTED, RC_NONE},
            '{FUNC_LIMIT, 32'd1, 1'b0, 32'd90, 32'd5, 1'b0, 1'b1, ST_REJECTED, RC_DUP_ID},
            '{FUNC_LIMIT, 32'd2, 1'b1, 32'd100, 32'd30, 1'b0, 1'b0, ST_REJECTED, RC_NONE},
            '{FUNC_LIMIT, 32'd3, 1'b1, QTY_SAT, QTY_SAT, 1'b0, 1'b0, ST_REJECTED, RC_NONE},
            '{FUNC_LIMIT, 32'd10, 1'b0, 32'd0, QTY_SAT, 1'b0, 1'b0, ST_REJECTED, RC_NONE},
            // two full-size bids at price zero saturate the level quantity
            '{FUNC_LIMIT, 32'd11, 1'b0, 32'd0, QTY_SAT, 1'b0, 1'b0, ST_REJECTED, RC_NONE},
            '{FUNC_LIMIT, 32'd12, 1'b0, 32'd100, 32'd60, 1'b0, 1'b0, ST_REJECTED, RC_NONE},
            '{FUNC_CANCEL, 32'd2, 1'b1, 32'd0, 32'd5, 1'b0, 1'b0, ST_REJECTED, RC_NONE},
            '{FUNC_CANCEL, 32'd2, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0, ST_REJECTED, RC_NONE},
            '{FUNC_MARKET, 32'd0, 1'b1, 32'd0, QTY_SAT, 1'b0, 1'b0, ST_REJECTED, RC_NONE},
            '{FUNC_LIMIT, QTY_SAT, 1'b1, 32'd50, 32'd7, 1'b0, 1'b0, ST_REJECTED, RC_NONE},
            '{FUNC_MARKET, 32'd9, 1'b0, 32'd0, 32'd20, 1'b0, 1'b0, ST_REJECTED, RC_NONE},
            '{FUNC_CANCEL, 32'd3, 1'b0, 32'd0, 32'hFFFF_FFF0, 1'b0, 1'b0, ST_REJECTED,
              RC_NONE},
            '{FUNC_CANCEL, 32'd3, 1'b1, 32'd0, QTY_SAT, 1'b0, 1'b0, ST_REJECTED, RC_NONE},
            '{FUNC_CANCEL, 32'd11, 1'b1, 32'd0, 32'd0, 1'b0, 1'b0, ST_REJECTED, RC_NONE}
        };
        for (int i = 0; i < DIRECTED_N; i++)
            orders = {orders, directed[i]};

        for (int i = 0; i < 45; i++)
            add_random_order();
        // fill the table with resting bids so the book-full path is reached
        for (int i = 0; i < 34; i++)
            add_order(FUNC_LIMIT, 32'd1000 + i, 1'b0, 32'($urandom_range(1, 5)), 32'd3);
        orders[orders.size() - 34].drain = 1'b1;
        add_order(FUNC_LIMIT, 32'd2000, 1'b1, 32'd1, 32'd1000);
        add_order(FUNC_MARKET, 32'd2001, 1'b1, 32'd0, 32'd200);
        for (int i = 0; i < 60; i++)
            add_random_order();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (next_order == orders.size());
        while (due_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("limit_order_book_matcher test passed");
        else
            $display("limit_order_book_matcher test failed");
        $finish;
    end

    // sender
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                match_event(orders[next_order]);
                if (orders[next_order].has_exp) begin
                    if (due_reports[$].status != orders[next_order].exp_status)
                        flag_mismatch("expected status", due_reports[$].status,
                                      orders[next_order].exp_status);
                    if (due_reports[$].cause != orders[next_order].exp_cause)
                        flag_mismatch("expected cause", due_reports[$].cause,
                                      orders[next_order].exp_cause);
                end
                next_order++;
                quiet = (orders.size() - next_order) <= QUIET_TAIL;
                if (!quiet && $urandom_range(0, 4) == 0)
                    in_gap = $urandom_range(1, 19);
            end
            if (!(in_valid && in_stall)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (next_order < orders.size() &&
                         !(orders[next_order].drain && due_reports.size() != 0)) begin
                    func <= orders[next_order].func;
                    ord_id <= orders[next_order].id;
                    side <= orders[next_order].side;
                    price <= orders[next_order].price;
                    qty <= orders[next_order].qty;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(posedge clk) begin
        if (out_hold > 0) begin
            out_hold--;
            out_stall <= 1'b1;
        end
        else if (rst_n && !quiet && $urandom_range(0, 9) == 0) begin
            out_hold = $urandom_range(0, 18);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // result checker
    always @(posedge clk) begin
        report_t w;
        if (rst_n && out_valid && !out_stall) begin
            if (due_reports.size() == 0) begin
                $display("result item with nothing expected");
                errors++;
            end
            else begin
                w = due_reports.pop_front();
                if (status !== w.status) flag_mismatch("status", 32'(status), 32'(w.status));
                if (reject_cause !== w.cause)
                    flag_mismatch("reject_cause", 32'(reject_cause), 32'(w.cause));
                if (resting_id !== w.rid) flag_mismatch("resting_id", resting_id, w.rid);
                if (trade_price !== w.tprice) flag_mismatch("trade_price", trade_price, w.tprice);
                if (fill_qty !== w.tqty) flag_mismatch("fill_qty", fill_qty, w.tqty);
                if (filled_total !== w.filled)
                    flag_mismatch("filled_total", filled_total, w.filled);
                if (left_qty !== w.left) flag_mismatch("left_qty", left_qty, w.left);
                if (bid_px !== w.bid) flag_mismatch("bid_px", bid_px, w.bid);
                if (bid_size !== w.bid_qty)
                    flag_mismatch("bid_size", bid_size, w.bid_qty);
                if (ask_px !== w.ask) flag_mismatch("ask_px", ask_px, w.ask);
                if (ask_size !== w.ask_qty)
                    flag_mismatch("ask_size", ask_size, w.ask_qty);
                if (last !== w.last) flag_mismatch("last", 32'(last), 32'(w.last));
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= DOG_LIMIT) begin
            $display("limit_order_book_matcher test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/lobm_pkg.sv
src/limit_order_book_matcher.sv
src/lobm_checker.sv
tb/sv/tb_top.sv
